### rtl/core/ulv_pkg.sv
// Shared types, constants and code point checks for the UTF-8 label validator.
package ulv_pkg;

    localparam int MAX_SCALARS_DEF = 64;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] LEAD_E0 = 8'he0;
    localparam logic [7:0] LEAD_ED = 8'hed;
    localparam logic [7:0] LEAD_F0 = 8'hf0;
    localparam logic [7:0] LEAD_F4 = 8'hf4;

    localparam logic [20:0] CP_MAX     = 21'h10ffff;
    localparam logic [20:0] SURR_FIRST = 21'h00d800;
    localparam logic [20:0] SURR_LAST  = 21'h00dfff;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } byte_class_t;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        empty;
        byte_class_t cls;
        logic        below_a0;
        logic        above_9f;
        logic        below_90;
        logic        above_8f;
    } byte_info_t;

    function automatic logic in_rng(logic [20:0] v, logic [20:0] lo, logic [20:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Control, format, bidi, private-use and noncharacter code points.
    function automatic logic forbidden_point(logic [20:0] c);
        logic [15:0] low16;
        logic        hit;
        low16 = c[15:0];
        hit = (c <= 21'h1f) || in_rng(c, 21'h7f, 21'h9f);
        hit = hit || (c == 21'had) || in_rng(c, 21'h600, 21'h605) || (c == 21'h61c)
            || (c == 21'h6dd) || (c == 21'h70f) || in_rng(c, 21'h890, 21'h891)
            || (c == 21'h8e2) || (c == 21'h180e) || in_rng(c, 21'h200b, 21'h200f)
            || in_rng(c, 21'h202a, 21'h202e) || in_rng(c, 21'h2060, 21'h2064)
            || in_rng(c, 21'h2066, 21'h206f) || (c == 21'hfeff)
            || in_rng(c, 21'hfff9, 21'hfffb) || (c == 21'h110bd) || (c == 21'h110cd)
            || in_rng(c, 21'h13430, 21'h1343f) || in_rng(c, 21'h1bca0, 21'h1bca3)
            || in_rng(c, 21'h1d173, 21'h1d17a) || (c == 21'he0001)
            || in_rng(c, 21'he0020, 21'he007f);
        hit = hit || in_rng(c, 21'he000, 21'hf8ff) || in_rng(c, 21'hf0000, 21'hffffd)
            || in_rng(c, 21'h100000, 21'h10fffd);
        hit = hit || in_rng(c, 21'hfdd0, 21'hfdef) || (low16 == 16'hfffe)
            || (low16 == 16'hffff);
        return hit;
    endfunction

endpackage

### rtl/core/ulv_front.sv
// Input side: accepts bytes and classifies them for the decoder.
module ulv_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // end_of_text
    input  logic               s_tuser,   // [0] empty_text
    input  logic               queue_full,
    output logic               push,
    output ulv_pkg::byte_info_t push_item
);

    ulv_pkg::byte_class_t cls;

    always_comb begin
        if (s_tdata <= 8'h7f) begin
            cls = ulv_pkg::CLS_ASCII;
        end else if (s_tdata <= 8'hbf) begin
            cls = ulv_pkg::CLS_CONT;
        end else if (s_tdata >= 8'hc2 && s_tdata <= 8'hdf) begin
            cls = ulv_pkg::CLS_LEAD2;
        end else if (s_tdata >= 8'he0 && s_tdata <= 8'hef) begin
            cls = ulv_pkg::CLS_LEAD3;
        end else if (s_tdata >= 8'hf0 && s_tdata <= 8'hf4) begin
            cls = ulv_pkg::CLS_LEAD4;
        end else begin
            cls = ulv_pkg::CLS_BAD;
        end
    end

    always_comb begin
        push_item.data     = s_tdata;
        push_item.last     = s_tlast;
        push_item.empty    = s_tuser;
        push_item.cls      = cls;
        // bounds on the first continuation byte after E0, ED, F0 and F4
        push_item.below_a0 = (s_tdata < 8'ha0);
        push_item.above_9f = (s_tdata > 8'h9f);
        push_item.below_90 = (s_tdata < 8'h90);
        push_item.above_8f = (s_tdata > 8'h8f);
    end

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

endmodule

### rtl/core/ulv_queue.sv
// Short queue of classified bytes between the front and the decoder.
module ulv_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  ulv_pkg::byte_info_t push_item,
    output logic                full,
    input  logic                pop,
    output ulv_pkg::byte_info_t pop_item,
    output logic                not_empty
);

    localparam int AW = ulv_pkg::QUEUE_AW;

    ulv_pkg::byte_info_t entry_reg [ulv_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   fill_reg,   fill_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(ulv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(ulv_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign pop_item  = entry_reg[rd_ptr_reg];
    assign full      = (fill_reg == (AW+1)'(ulv_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);

endmodule

### rtl/core/ulv_back.sv
// Decoder: assembles code points, applies label rules and registers the result.
module ulv_back #(
    parameter int MAX_SCALARS = ulv_pkg::MAX_SCALARS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  ulv_pkg::byte_info_t item,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata
);

    localparam int CW = $clog2(MAX_SCALARS + 2);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SCALARS);

    logic [2:0]    seq_len_reg,  seq_len_next;
    logic [1:0]    pending_reg,  pending_next;
    logic [7:0]    lead_reg,     lead_next;
    logic [20:0]   partial_reg,  partial_next;
    logic [CW-1:0] total_reg,    total_next;
    logic          failed_reg,   failed_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_ok_reg,   out_ok_next;
    logic [6:0]    out_count_reg, out_count_next;

    logic          fin;
    logic [20:0]   cp;
    logic [20:0]   shifted;
    logic          first_cont;
    logic          range_bad;
    logic [CW+6:0] total_wide;

    // Advance when a byte waits and its result, if any, has a free output slot.
    assign pop = item_valid && (!item.last || !out_valid_reg || m_tready);

    assign shifted    = {partial_reg[14:0], item.data[5:0]};
    assign first_cont = ({1'b0, pending_reg} == (seq_len_reg - 3'd1));
    assign range_bad  = (lead_reg == ulv_pkg::LEAD_E0 && item.below_a0)
                     || (lead_reg == ulv_pkg::LEAD_ED && item.above_9f)
                     || (lead_reg == ulv_pkg::LEAD_F0 && item.below_90)
                     || (lead_reg == ulv_pkg::LEAD_F4 && item.above_8f);

    always_comb begin
        seq_len_next   = seq_len_reg;
        pending_next   = pending_reg;
        lead_next      = lead_reg;
        partial_next   = partial_reg;
        total_next     = total_reg;
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        out_count_next = out_count_reg;
        fin            = 1'b0;
        cp             = shifted;
        total_wide     = '0;

        if (pop) begin
            if (item.empty) begin
                failed_next = 1'b1;
            end else if (!failed_reg) begin
                if (pending_reg == 2'd0) begin
                    lead_next = item.data;
                    case (item.cls)
                        ulv_pkg::CLS_ASCII: begin
                            seq_len_next = 3'd1;
                            partial_next = {13'd0, item.data};
                            cp           = {13'd0, item.data};
                            fin          = 1'b1;
                        end
                        ulv_pkg::CLS_LEAD2: begin
                            seq_len_next = 3'd2;
                            pending_next = 2'd1;
                            partial_next = {16'd0, item.data[4:0]};
                        end
                        ulv_pkg::CLS_LEAD3: begin
                            seq_len_next = 3'd3;
                            pending_next = 2'd2;
                            partial_next = {17'd0, item.data[3:0]};
                        end
                        ulv_pkg::CLS_LEAD4: begin
                            seq_len_next = 3'd4;
                            pending_next = 2'd3;
                            partial_next = {18'd0, item.data[2:0]};
                        end
                        default: begin
                            failed_next = 1'b1;
                        end
                    endcase
                end else if (item.cls != ulv_pkg::CLS_CONT) begin
                    failed_next = 1'b1;
                end else if (first_cont && range_bad) begin
                    failed_next = 1'b1;
                end else begin
                    partial_next = shifted;
                    pending_next = pending_reg - 2'd1;
                    fin          = (pending_reg == 2'd1);
                end

                if (fin) begin
                    if (cp > ulv_pkg::CP_MAX
                        || ulv_pkg::in_rng(cp, ulv_pkg::SURR_FIRST, ulv_pkg::SURR_LAST)
                        || ulv_pkg::forbidden_point(cp)) begin
                        failed_next = 1'b1;
                    end else begin
                        total_next = total_reg + 1'b1;
                        if (total_reg == MAX_C) begin
                            failed_next = 1'b1;
                        end
                    end
                end
            end

            if (item.last) begin
                // A sequence left open at the end spoils the label.
                total_wide     = {7'd0, total_next};
                out_valid_next = 1'b1;
                out_ok_next    = !(failed_next || pending_next != 2'd0);
                out_count_next = out_ok_next ? total_wide[6:0] : 7'd0;
                seq_len_next   = '0;
                pending_next   = '0;
                lead_next      = '0;
                partial_next   = '0;
                total_next     = '0;
                failed_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_len_reg   <= '0;
            pending_reg   <= '0;
            lead_reg      <= '0;
            partial_reg   <= '0;
            total_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            seq_len_reg   <= seq_len_next;
            pending_reg   <= pending_next;
            lead_reg      <= lead_next;
            partial_reg   <= partial_next;
            total_reg     <= total_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ok_reg    <= out_ok_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_ok_reg};

endmodule

### rtl/core/utf8_label_validator.sv
// Top level of the UTF-8 label validator: front classifier, queue and decoder.
//
// Usage:
//   The slave channel takes one label byte per item: s_tdata carries the byte,
//   s_tlast marks the last item of the label and s_tuser flags an empty label
//   (sent as a single item with s_tlast high; its byte is ignored).
//   The master channel gives one item per label, on the label's last byte:
//   m_tdata[0] is the valid flag, m_tdata[7:1] the scalar count (zero when the
//   label is rejected).
//   Path: the last byte is written into the queue, which reads out
//   combinationally to the decoder; the result for the label is then held in
//   the result register.
//   Throughput: one byte per cycle while the queue has room; the decoder
//   retires one queued byte a cycle unless a label end waits on m_tready.
//   Stalls: while a result waits on m_tready, the decoder still retires bytes
//   that produce no result; a label end waits, the queue fills, and s_tready
//   drops once the queue holds four bytes.
//   Reset: aresetn low at a clock edge empties the queue, drops the result and
//   clears the decoder, so the next byte starts a new label.
module utf8_label_validator #(
    parameter int MAX_SCALARS = ulv_pkg::MAX_SCALARS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_text
    input  logic       s_tuser,   // [0] empty_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] label_valid, [7:1] scalar count
);

    logic                push;
    logic                queue_full;
    logic                pop;
    logic                queue_has_item;
    ulv_pkg::byte_info_t push_item;
    ulv_pkg::byte_info_t pop_item;

    // Classify each byte as it is accepted.
    ulv_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .s_tuser    (s_tuser),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Hold classified bytes while the decoder waits on the result channel.
    ulv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_has_item)
    );

    // Decode sequences, check code points and count scalars.
    ulv_back #(
        .MAX_SCALARS (MAX_SCALARS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_has_item),
        .item       (pop_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

### test/utf8_label_validator_tb.sv
// Self-checking testbench for the UTF-8 label validator: byte stream in, verdict per label out.
module utf8_label_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LIMIT_SCALARS   = ulv_pkg::MAX_SCALARS_DEF;
    localparam int     ITEM_TARGET     = 2000;
    localparam int     HOLD_OFF_CYCLES = 64;   // long receiver stall, well past queue depth
    localparam int     DRAIN_CYCLES    = 8;
    localparam longint TIMEOUT_NS      = 1000000;

    // Tracks the decoder state of the current label and keeps the verdicts that the
    // labels already closed are still owed.
    class label_scoreboard;
        typedef struct packed {
            logic       ok;
            logic [6:0] count;
        } verdict_t;

        verdict_t    verdicts_due[$];
        int          max_scalars;
        int          errors;
        int          labels_total;
        int          labels_ok;
        int          empty_flags;
        logic [2:0]  seq_len;
        logic [1:0]  cont_left;
        logic [7:0]  lead;
        logic [20:0] point;
        int          total;
        logic        failed;

        function new(int max_scalars_in);
            max_scalars = max_scalars_in;
            clear_label();
        endfunction

        function void clear_label();
            seq_len   = '0;
            cont_left = '0;
            lead      = '0;
            point     = '0;
            total     = 0;
            failed    = 1'b0;
        endfunction

        function logic in_span(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
            return (c >= lo) && (c <= hi);
        endfunction

        // Controls, format and bidi marks, private use and noncharacters.
        function logic banned_point(logic [20:0] c);
            if (c <= 21'h1f || in_span(c, 21'h7f, 21'h9f))
                return 1'b1;
            if (c == 21'had || in_span(c, 21'h600, 21'h605) || c == 21'h61c
                || c == 21'h6dd || c == 21'h70f || in_span(c, 21'h890, 21'h891)
                || c == 21'h8e2 || c == 21'h180e || in_span(c, 21'h200b, 21'h200f)
                || in_span(c, 21'h202a, 21'h202e) || in_span(c, 21'h2060, 21'h2064)
                || in_span(c, 21'h2066, 21'h206f) || c == 21'hfeff
                || in_span(c, 21'hfff9, 21'hfffb) || c == 21'h110bd || c == 21'h110cd
                || in_span(c, 21'h13430, 21'h1343f) || in_span(c, 21'h1bca0, 21'h1bca3)
                || in_span(c, 21'h1d173, 21'h1d17a) || c == 21'he0001
                || in_span(c, 21'he0020, 21'he007f))
                return 1'b1;
            if (in_span(c, 21'he000, 21'hf8ff) || in_span(c, 21'hf0000, 21'hffffd)
                || in_span(c, 21'h100000, 21'h10fffd))
                return 1'b1;
            return in_span(c, 21'hfdd0, 21'hfdef) || c[15:0] == 16'hfffe
                || c[15:0] == 16'hffff;
        endfunction

        function void close_scalar(logic [20:0] c);
            if (c > 21'h10ffff || in_span(c, 21'hd800, 21'hdfff) || banned_point(c)) begin
                failed = 1'b1;
                return;
            end
            // count saturates one past the limit
            if (total <= max_scalars)
                total++;
            if (total > max_scalars)
                failed = 1'b1;
        endfunction

        function void decode_byte(logic [7:0] b);
            if (failed)
                return;
            if (cont_left == 2'd0) begin
                lead = b;
                if (b <= 8'h7f) begin
                    seq_len = 3'd1;
                    point   = {13'd0, b};
                    close_scalar(point);
                    return;
                end else if (b >= 8'hc2 && b <= 8'hdf) begin
                    seq_len = 3'd2;
                    point   = {16'd0, b[4:0]};
                end else if (b >= 8'he0 && b <= 8'hef) begin
                    seq_len = 3'd3;
                    point   = {17'd0, b[3:0]};
                end else if (b >= 8'hf0 && b <= 8'hf4) begin
                    seq_len = 3'd4;
                    point   = {18'd0, b[2:0]};
                end else begin
                    failed = 1'b1;
                    return;
                end
                cont_left = seq_len[1:0] - 2'd1;
                return;
            end
            if (b[7:6] != 2'b10) begin
                failed = 1'b1;
                return;
            end
            // first continuation byte narrows the range after some leads
            if ({1'b0, cont_left} == seq_len - 3'd1) begin
                if ((lead == 8'he0 && b < 8'ha0) || (lead == 8'hed && b > 8'h9f)
                    || (lead == 8'hf0 && b < 8'h90) || (lead == 8'hf4 && b > 8'h8f)) begin
                    failed = 1'b1;
                    return;
                end
            end
            point     = {point[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0)
                close_scalar(point);
        endfunction

        // Take one accepted input item; queue a verdict when it ends the label.
        function void note_item(logic [7:0] b, logic last, logic empty);
            verdict_t v;
            if (empty) begin
                failed = 1'b1;
                empty_flags++;
            end else begin
                decode_byte(b);
            end
            if (!last)
                return;
            if (cont_left != 2'd0)
                failed = 1'b1;
            v.ok    = !failed;
            v.count = failed ? 7'd0 : total[6:0];
            verdicts_due.insert(verdicts_due.size(), v);
            labels_total++;
            if (v.ok)
                labels_ok++;
            clear_label();
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        task check_verdict(logic [7:0] word);
            verdict_t want;
            if (verdicts_due.size() == 0) begin
                report($sformatf("result %02h arrived with no label closed", word));
                return;
            end
            want = verdicts_due.pop_front();
            if (word[0] !== want.ok)
                report($sformatf("label_valid %b, predicted %b", word[0], want.ok));
            if (word[7:1] !== want.count)
                report($sformatf("scalar count %0d, predicted %0d", word[7:1], want.count));
        endtask

        task flush_leftovers();
            if (verdicts_due.size() != 0)
                report($sformatf("%0d label verdicts never arrived", verdicts_due.size()));
        endtask
    endclass

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_tlast  = 1'b0;    // end_of_text
    logic       s_tuser  = 1'b0;    // [0] empty_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [0] label_valid, [7:1] scalar count

    label_scoreboard sb;

    logic [7:0] label_bytes[$];     // the label being built, one byte per item
    int         empty_slot    = -1; // index that carries the empty flag, -1 for none
    logic       quiet         = 1'b0;
    logic       hold_off_req  = 1'b0;
    int         items_sent    = 0;
    int         stall_cycles  = 0;
    int         hold_offs     = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    utf8_label_validator #(
        .MAX_SCALARS(LIMIT_SCALARS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Sample both channels at the rising edge; feed accepted bytes to the predictor
    // and check every accepted result against the oldest owed verdict.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_item(s_tdata, s_tlast, s_tuser);
            if (m_tvalid && m_tready)
                sb.check_verdict(m_tdata);
            if (s_tvalid && !s_tready)
                stall_cycles++;
        end
    end

    // Gap length for either side: mostly none or short, now and then long.
    // Quiet stretches and the long hold-off keep the sender at full rate.
    function automatic int pick_gap();
        int r;
        if (quiet || hold_off_req)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random back-pressure, plus one long hold-off on request so the
    // queue fills behind a waiting result and s_tready drops.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    // Offer one item, starting at a falling edge; return at the falling edge after
    // it was taken. Valid stays high when the next item follows without a gap.
    task automatic push_item(input logic [7:0] b, input logic last, input logic empty);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        s_tuser  = empty;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Add one byte at the tail of the label being built.
    function automatic void append_byte(logic [7:0] b);
        label_bytes.insert(label_bytes.size(), b);
    endfunction

    // Send the built label with tlast on its final byte, then clear it.
    task automatic send_label();
        int n;
        if (label_bytes.size() == 0)
            append_byte(8'h41);
        n = label_bytes.size();
        for (int i = 0; i < n; i++)
            push_item(label_bytes[i], i == n - 1, i == empty_slot);
        label_bytes.delete();
        empty_slot = -1;
    endtask

    // Send n raw bytes taken from the top of seq downward.
    task automatic send_raw(input int n, input logic [31:0] seq);
        for (int i = 0; i < n; i++)
            append_byte(seq[31 - 8*i -: 8]);
        send_label();
    endtask

    function automatic void append_point(logic [20:0] cp);
        if (cp < 21'h80) begin
            append_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end else begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
        end
    endfunction

    // Code points on or just beside the edges of the rejected ranges.
    function automatic logic [20:0] edge_point(int k);
        case (k)
            0:       return 21'h000000;
            1:       return 21'h00001f;
            2:       return 21'h000020;
            3:       return 21'h00007f;
            4:       return 21'h00009f;
            5:       return 21'h0000a0;
            6:       return 21'h0000ad;
            7:       return 21'h00061c;
            8:       return 21'h00200b;
            9:       return 21'h00202e;
            10:      return 21'h00feff;
            11:      return 21'h00fdd0;
            12:      return 21'h00fdef;
            13:      return 21'h00fdf0;
            14:      return 21'h00fffe;
            15:      return 21'h01ffff;
            16:      return 21'h0e0001;
            17:      return 21'h0e007f;
            18:      return 21'h00e000;
            19:      return 21'h00f8ff;
            20:      return 21'h00f900;
            21:      return 21'h10fffd;
            22:      return 21'h10ffff;
            23:      return 21'h00d800;
            default: return 21'h00dfff;
        endcase
    endfunction

    // Mostly printable text, with a thin spread of wider and rejected points.
    function automatic logic [20:0] pick_point();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 21'($urandom_range(21'h20, 21'h7e));
        if (r < 60)
            return 21'($urandom_range(21'ha0, 21'h7ff));
        if (r < 75)
            return 21'($urandom_range(21'h800, 21'hd7ff));
        if (r < 82)
            return 21'($urandom_range(21'h800, 21'hffff));
        if (r < 94)
            return 21'($urandom_range(21'h10000, 21'h10ffff));
        if (r < 97)
            return edge_point($urandom_range(0, 24));
        // past the top of the code space; encodes with an F4 lead and a high second byte
        return 21'($urandom_range(21'h110000, 21'h13ffff));
    endfunction

    // Break a well-formed label in one spot.
    function automatic void mutate_label();
        int idx;
        idx = $urandom_range(0, label_bytes.size() - 1);
        case ($urandom_range(0, 4))
            0: label_bytes[idx] = 8'($urandom_range(0, 255));
            1: if (label_bytes.size() > 1) void'(label_bytes.pop_back());
            2: case ($urandom_range(0, 3))
                   0:       label_bytes.insert(idx, 8'hc0);
                   1:       label_bytes.insert(idx, 8'hc1);
                   2:       label_bytes.insert(idx, 8'hf5);
                   default: label_bytes.insert(idx, 8'hff);
               endcase
            3: empty_slot = idx;
            default: label_bytes[idx] = {2'b10, 6'($urandom_range(0, 63))};
        endcase
    endfunction

    function automatic void build_label(int label_no);
        int r;
        int n;
        r = $urandom_range(0, 99);
        // pin the scalar limit exactly once on each side
        if (label_no == 3 || label_no == 4) begin
            n = (label_no == 3) ? LIMIT_SCALARS : LIMIT_SCALARS + 1;
            for (int i = 0; i < n; i++)
                append_point(21'($urandom_range(21'h21, 21'h7e)));
        end else if (r < 4) begin
            append_byte(8'($urandom_range(0, 255)));
            empty_slot = 0;
        end else if (r < 10) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                append_byte(8'($urandom_range(0, 255)));
        end else begin
            n = ($urandom_range(0, 99) < 4) ? $urandom_range(LIMIT_SCALARS - 4, LIMIT_SCALARS + 4)
                                            : $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                append_point(pick_point());
            if (r < 25)
                mutate_label();
        end
    endfunction

    initial begin
        #(TIMEOUT_NS);
        $display("timeout: stimulus or results stuck");
        $display("utf8_label_validator_tb: done, errors");
        $finish;
    end

    initial begin
        int label_no;
        sb = new(LIMIT_SCALARS);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed labels.
        append_byte(8'hff);                 // empty label, byte ignored
        empty_slot = 0;
        send_label();
        append_byte(8'h41);                 // empty flag on the first of two bytes, no result until the end
        append_byte(8'h42);
        empty_slot = 0;
        send_label();
        send_raw(1, 32'h00000000);          // NUL control
        send_raw(1, 32'h7e000000);          // highest printable ASCII, passes
        send_raw(2, 32'hc0af0000);          // overlong lead; the byte after it is ignored
        send_raw(3, 32'he09fbf00);          // overlong three-byte form
        send_raw(3, 32'heda08000);          // surrogate
        send_raw(4, 32'hf4908080);          // above the code space
        send_raw(2, 32'he2820000);          // sequence cut off by the label end
        send_raw(2, 32'hc2410000);          // missing continuation byte
        send_raw(4, 32'hf09f9880);          // four-byte scalar, passes
        send_raw(3, 32'hefb79000);          // noncharacter

        // Random labels until the byte budget is spent.
        label_no = 0;
        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 99) < 15);
            if (label_no == 40 || label_no == 160) begin
                hold_off_req = 1'b1;
                hold_offs++;
            end
            build_label(label_no);
            send_label();
            label_no++;
        end
        s_tvalid = 1'b0;

        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.flush_leftovers();

        $display("summary: %0d labels over %0d byte items, %0d predicted valid, %0d empty flags",
                 sb.labels_total, items_sent, sb.labels_ok, sb.empty_flags);
        $display("summary: %0d input stall cycles, %0d long result hold-offs, %0d mismatches",
                 stall_cycles, hold_offs, sb.errors);
        if (sb.errors == 0)
            $display("utf8_label_validator_tb: done, clean");
        else
            $display("utf8_label_validator_tb: done, errors");
        $finish;
    end

endmodule

### utf8_label_validator.f
rtl/core/ulv_pkg.sv
rtl/core/ulv_front.sv
rtl/core/ulv_queue.sv
rtl/core/ulv_back.sv
rtl/core/utf8_label_validator.sv
test/utf8_label_validator_tb.sv
